>>> rtl/sensor_frame_crc_checker_unit_assert.svh
// Assertion macros for the sensor frame CRC checker.
// Used by the top level; expects clk and rst_n in scope.
`ifndef SENSOR_FRAME_CRC_CHECKER_UNIT_ASSERT_SVH
`define SENSOR_FRAME_CRC_CHECKER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SFCC_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define SFCC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define SFCC_ASSERT_ALWAYS(lbl, expr, msg)
`define SFCC_ASSERT_IMPLIES(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/sfcc_pkg.sv
// Shared types, constants and the CRC-8 step for the sensor frame checker.
// No dependencies.
package sfcc_pkg;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  localparam logic [2:0] POS_FIRST_HI  = 3'd0;
  localparam logic [2:0] POS_FIRST_LO  = 3'd1;
  localparam logic [2:0] POS_FIRST_CRC = 3'd2;
  localparam logic [2:0] POS_SECOND_HI = 3'd3;
  localparam logic [2:0] POS_SECOND_LO = 3'd4;
  localparam logic [2:0] POS_LAST      = 3'd5;

  localparam logic [2:0] MAX_ATTEMPTS_RST = 3'd3;

  localparam int         CFG_ADDR_W       = 3;
  localparam logic       REG_MAX_ATTEMPTS = 1'b0;

  localparam logic       KIND_BYTE     = 1'b0;
  localparam logic       KIND_BUS_FAIL = 1'b1;

  typedef enum logic [1:0] {
    ST_VALID    = 2'd0,
    ST_CRC_BAD  = 2'd1,
    ST_BUS_FAIL = 2'd2
  } status_t;

  typedef struct packed {
    status_t     status;
    logic        give_up;
    logic [15:0] temperature_word;
    logic [15:0] humidity_word;
    logic [2:0]  attempt_number;
  } result_t;

  // MSB-first CRC-8 update over one byte, no reflection
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
    end
    return v;
  endfunction

endpackage

>>> rtl/sfcc_if.sv
// Valid/ready channel interfaces for the sensor frame checker.
// No dependencies.
interface sfcc_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] frame_byte;
  modport source (output valid, kind, frame_byte, input ready);
  modport sink   (input valid, kind, frame_byte, output ready);
endinterface

interface sfcc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        give_up;
  logic [15:0] temperature_word;
  logic [15:0] humidity_word;
  logic [2:0]  attempt_number;
  modport source (output valid, status, give_up, temperature_word, humidity_word,
                  attempt_number, input ready);
  modport sink   (input valid, status, give_up, temperature_word, humidity_word,
                  attempt_number, output ready);
endinterface

>>> rtl/sfcc_cfg.sv
// APB-style register file holding max_attempts.
// Depends on sfcc_pkg.
module sfcc_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sfcc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output logic [2:0]                      max_attempts
);

  logic [2:0] max_attempts_r;
  logic       wr_en;
  logic       sel_max;

  // register index is paddr / 4
  assign sel_max = (paddr[sfcc_pkg::CFG_ADDR_W-1] == sfcc_pkg::REG_MAX_ATTEMPTS);
  assign wr_en   = psel && penable && pwrite && sel_max;
  assign pready  = 1'b1;
  assign prdata  = sel_max ? {29'd0, max_attempts_r} : 32'd0;
  assign max_attempts = max_attempts_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_attempts_r <= sfcc_pkg::MAX_ATTEMPTS_RST;
    end else if (wr_en) begin
      max_attempts_r <= pwdata[2:0];
    end
  end

endmodule

>>> rtl/sfcc_frame.sv
// Frame state, CRC checking and attempt counting for one staged item.
// Depends on sfcc_pkg.
module sfcc_frame (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic                kind,
  input  logic [7:0]          frame_byte,
  input  logic [2:0]          max_attempts,
  output logic                has_result,
  output sfcc_pkg::result_t   result
);

  logic [2:0]  byte_pos_r,   byte_pos_nxt;
  logic [7:0]  crc_r,        crc_nxt;
  logic [15:0] first_word_r, first_word_nxt;
  logic [15:0] second_word_r, second_word_nxt;
  logic        first_ok_r,   first_ok_nxt;
  logic [2:0]  attempts_r,   attempts_nxt;

  logic [7:0]  crc_upd;
  logic [2:0]  limit;
  logic [3:0]  att_inc;
  logic        give_up;
  logic        frame_ok;

  assign crc_upd  = sfcc_pkg::crc8_feed(crc_r, frame_byte);
  assign limit    = (max_attempts == 3'd0) ? 3'd1 : max_attempts;
  assign att_inc  = {1'b0, attempts_r} + 4'd1;
  assign give_up  = (att_inc >= {1'b0, limit});
  assign frame_ok = first_ok_r && (crc_r == frame_byte);

  always_comb begin
    byte_pos_nxt    = byte_pos_r;
    crc_nxt         = crc_r;
    first_word_nxt  = first_word_r;
    second_word_nxt = second_word_r;
    first_ok_nxt    = first_ok_r;
    attempts_nxt    = attempts_r;
    has_result      = 1'b0;
    result          = '0;
    result.attempt_number = attempts_r;

    if (kind == sfcc_pkg::KIND_BUS_FAIL) begin
      has_result     = 1'b1;
      result.status  = sfcc_pkg::ST_BUS_FAIL;
      result.give_up = give_up;
      attempts_nxt   = give_up ? 3'd0 : att_inc[2:0];
      byte_pos_nxt   = sfcc_pkg::POS_FIRST_HI;
      crc_nxt        = sfcc_pkg::CRC_INIT;
      first_ok_nxt   = 1'b0;
    end else begin
      case (byte_pos_r)
        sfcc_pkg::POS_FIRST_HI: begin
          first_word_nxt = {frame_byte, first_word_r[7:0]};
          crc_nxt        = crc_upd;
          byte_pos_nxt   = sfcc_pkg::POS_FIRST_LO;
        end
        sfcc_pkg::POS_FIRST_LO: begin
          first_word_nxt = {first_word_r[15:8], frame_byte};
          crc_nxt        = crc_upd;
          byte_pos_nxt   = sfcc_pkg::POS_FIRST_CRC;
        end
        sfcc_pkg::POS_FIRST_CRC: begin
          first_ok_nxt = (crc_r == frame_byte);
          crc_nxt      = sfcc_pkg::CRC_INIT;
          byte_pos_nxt = sfcc_pkg::POS_SECOND_HI;
        end
        sfcc_pkg::POS_SECOND_HI: begin
          second_word_nxt = {frame_byte, second_word_r[7:0]};
          crc_nxt         = crc_upd;
          byte_pos_nxt    = sfcc_pkg::POS_SECOND_LO;
        end
        sfcc_pkg::POS_SECOND_LO: begin
          second_word_nxt = {second_word_r[15:8], frame_byte};
          crc_nxt         = crc_upd;
          byte_pos_nxt    = sfcc_pkg::POS_LAST;
        end
        default: begin
          // final CRC byte, and the unreachable positions past it
          has_result   = 1'b1;
          byte_pos_nxt = sfcc_pkg::POS_FIRST_HI;
          crc_nxt      = sfcc_pkg::CRC_INIT;
          first_ok_nxt = 1'b0;
          if (frame_ok) begin
            result.status           = sfcc_pkg::ST_VALID;
            result.temperature_word = first_word_r;
            result.humidity_word    = second_word_r;
            attempts_nxt            = 3'd0;
          end else begin
            result.status  = sfcc_pkg::ST_CRC_BAD;
            result.give_up = give_up;
            attempts_nxt   = give_up ? 3'd0 : att_inc[2:0];
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r <= sfcc_pkg::POS_FIRST_HI;
      crc_r      <= sfcc_pkg::CRC_INIT;
      first_ok_r <= 1'b0;
      attempts_r <= 3'd0;
    end else if (step) begin
      byte_pos_r <= byte_pos_nxt;
      crc_r      <= crc_nxt;
      first_ok_r <= first_ok_nxt;
      attempts_r <= attempts_nxt;
    end
  end

  // words are always written within a frame before they are reported
  always_ff @(posedge clk) begin
    if (step) begin
      first_word_r  <= first_word_nxt;
      second_word_r <= second_word_nxt;
    end
  end

endmodule

>>> rtl/sensor_frame_crc_checker_unit.sv
// Sensor frame CRC checker top level: input stage, frame logic, result register.
// Depends on sfcc_pkg, sfcc_if, sfcc_cfg, sfcc_frame and the assertion header.
// Usage:
//  - in_ch carries one item per handshake: kind 0 is a received frame byte,
//    kind 1 is a bus failure. Six bytes make a frame: temperature word,
//    its CRC-8, humidity word, its CRC-8 (poly 0x31, init 0xFF).
//  - out_ch carries one result after the sixth byte, or after any bus failure:
//    status, give_up, the two raw words (zero unless status is valid) and the
//    zero-based attempt number.
//  - The APB port holds max_attempts at address 0 (reset 3, 0 acts as 1).
//    Write it only while no item is in flight.
//  - A result item's cause is captured in the input register when accepted;
//    the result goes to the result register, which presents it on out_ch.
//  - Throughput: one item per cycle while out_ch is not stalled; the CRC byte
//    update and the frame checks are combinational between the two registers.
//  - When out_ch stalls, the result register holds; items that produce no
//    result keep flowing, and an item that would produce one waits in the
//    input register, which then drops in_ch.ready.
//  - Reset (rst_n low, synchronous) empties both registers, restarts the frame
//    and clears the attempt count; max_attempts returns to 3.
`include "sensor_frame_crc_checker_unit_assert.svh"

module sensor_frame_crc_checker_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  sfcc_in_if.sink                         in_ch,
  sfcc_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sfcc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  // input register
  logic       stg_valid_r;
  logic       stg_kind_r;
  logic [7:0] stg_byte_r;

  // result register
  logic                out_valid_r, out_valid_nxt;
  sfcc_pkg::result_t   out_data_r;

  logic                slot_free;
  logic                step;
  logic                has_result;
  sfcc_pkg::result_t   result;
  logic [2:0]          max_attempts;

  sfcc_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .max_attempts (max_attempts)
  );

  sfcc_frame u_frame (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .kind         (stg_kind_r),
    .frame_byte   (stg_byte_r),
    .max_attempts (max_attempts),
    .has_result   (has_result),
    .result       (result)
  );

  // result slot opens when empty or being drained this cycle
  assign slot_free   = !out_valid_r || out_ch.ready;
  // staged item retires unless it needs the slot and the slot is busy
  assign step        = stg_valid_r && (!has_result || slot_free);
  assign in_ch.ready = !stg_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      stg_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      stg_kind_r <= in_ch.kind;
      stg_byte_r <= in_ch.frame_byte;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (slot_free) begin
      out_valid_nxt = step && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && step && has_result) begin
      out_data_r <= result;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = out_data_r.status;
  assign out_ch.give_up          = out_data_r.give_up;
  assign out_ch.temperature_word = out_data_r.temperature_word;
  assign out_ch.humidity_word    = out_data_r.humidity_word;
  assign out_ch.attempt_number   = out_data_r.attempt_number;

  `SFCC_ASSERT_IMPLIES(a_no_overwrite, step && has_result, slot_free, "result slot overwritten")
  `SFCC_ASSERT_IMPLIES(a_ok_no_giveup,
                       out_valid_r && out_data_r.status == sfcc_pkg::ST_VALID,
                       !out_data_r.give_up, "give_up on valid frame")
  `SFCC_ASSERT_IMPLIES(a_fail_zero_words,
                       out_valid_r && out_data_r.status != sfcc_pkg::ST_VALID,
                       out_data_r.temperature_word == 16'd0 &&
                       out_data_r.humidity_word == 16'd0, "failure carries data")
  `SFCC_ASSERT_IMPLIES(a_attempt_range, out_valid_r, out_data_r.attempt_number != 3'd7,
                       "attempt number out of range")

endmodule

>>> sim/sensor_frame_crc_checker_unit_tb.sv
// Self-checking testbench for sensor_frame_crc_checker_unit.
// Needs sfcc_pkg, the sfcc_in_if/sfcc_out_if interfaces and the RTL top level.
// Predicts every result item from the accepted input items and checks it field by field.
`timescale 1ns / 1ps

module sensor_frame_crc_checker_unit_tb;

  // byte address of max_attempts: register 0, 4 bytes per register
  localparam logic [sfcc_pkg::CFG_ADDR_W-1:0] ADDR_MAX_ATTEMPTS =
    {sfcc_pkg::REG_MAX_ATTEMPTS, 2'b00};
  // item is in the input register, then the result register; give it margin
  localparam int DRAIN_CYCLES = 4;
  localparam int END_WAIT_LIMIT = 5000;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [sfcc_pkg::CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sfcc_in_if  in_ch ();
  sfcc_out_if out_ch ();

  sensor_frame_crc_checker_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // ---------------------------------------------------------------------------
  // Frame predictor state: a private copy of what the block should hold.
  // ---------------------------------------------------------------------------
  logic [2:0]  frame_pos;
  logic [7:0]  crc_acc;
  logic [15:0] temp_word;
  logic [15:0] hum_word;
  logic        temp_crc_ok;
  logic [2:0]  fail_count;
  logic [2:0]  attempt_limit;

  sfcc_pkg::result_t pending_results[$];

  // knobs shared by the sender, the receiver and the tests
  bit          gaps_on;
  bit          stalls_on;
  int unsigned long_hold;

  // bookkeeping
  int unsigned mismatch_count;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned valid_seen;
  int unsigned crc_bad_seen;
  int unsigned bus_fail_seen;
  int unsigned give_up_seen;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bit-serial CRC-8, MSB first, poly 0x31, no reflection.
  function automatic logic [7:0] crc8_bitwise(input logic [7:0] crc_in,
                                              input logic [7:0] data);
    logic [7:0] c;
    logic       fb;
    c = crc_in;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ data[i];
      c  = {c[6:0], 1'b0} ^ (fb ? sfcc_pkg::CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  function automatic logic [7:0] word_crc(input logic [15:0] w);
    return crc8_bitwise(crc8_bitwise(sfcc_pkg::CRC_INIT, w[15:8]), w[7:0]);
  endfunction

  task automatic restart_frame_model();
    frame_pos   = sfcc_pkg::POS_FIRST_HI;
    crc_acc     = sfcc_pkg::CRC_INIT;
    temp_crc_ok = 1'b0;
  endtask

  // Failed attempt: report the current index, then bump or wrap the count.
  // A limit of zero behaves as one.
  task automatic record_failure(input sfcc_pkg::status_t st);
    sfcc_pkg::result_t r;
    logic [3:0]        lim;
    lim = (attempt_limit == 3'd0) ? 4'd1 : {1'b0, attempt_limit};
    r.status           = st;
    r.temperature_word = 16'h0000;
    r.humidity_word    = 16'h0000;
    r.attempt_number   = fail_count;
    if ({1'b0, fail_count} + 4'd1 >= lim) begin
      r.give_up  = 1'b1;
      fail_count = 3'd0;
    end else begin
      r.give_up  = 1'b0;
      fail_count = fail_count + 3'd1;
    end
    pending_results.push_back(r);
  endtask

  // Advance the predictor by one accepted item; queue the result it causes.
  task automatic predict_frame_item(input logic kind, input logic [7:0] b);
    sfcc_pkg::result_t r;
    logic              ok;
    if (kind == sfcc_pkg::KIND_BUS_FAIL) begin
      restart_frame_model();
      record_failure(sfcc_pkg::ST_BUS_FAIL);
    end else begin
      case (frame_pos)
        sfcc_pkg::POS_FIRST_HI: begin
          temp_word[15:8] = b;
          crc_acc   = crc8_bitwise(crc_acc, b);
          frame_pos = sfcc_pkg::POS_FIRST_LO;
        end
        sfcc_pkg::POS_FIRST_LO: begin
          temp_word[7:0] = b;
          crc_acc   = crc8_bitwise(crc_acc, b);
          frame_pos = sfcc_pkg::POS_FIRST_CRC;
        end
        sfcc_pkg::POS_FIRST_CRC: begin
          temp_crc_ok = (crc_acc == b);
          crc_acc     = sfcc_pkg::CRC_INIT;
          frame_pos   = sfcc_pkg::POS_SECOND_HI;
        end
        sfcc_pkg::POS_SECOND_HI: begin
          hum_word[15:8] = b;
          crc_acc   = crc8_bitwise(crc_acc, b);
          frame_pos = sfcc_pkg::POS_SECOND_LO;
        end
        sfcc_pkg::POS_SECOND_LO: begin
          hum_word[7:0] = b;
          crc_acc   = crc8_bitwise(crc_acc, b);
          frame_pos = sfcc_pkg::POS_LAST;
        end
        default: begin
          ok = temp_crc_ok && (crc_acc == b);
          restart_frame_model();
          if (ok) begin
            r.status           = sfcc_pkg::ST_VALID;
            r.give_up          = 1'b0;
            r.temperature_word = temp_word;
            r.humidity_word    = hum_word;
            r.attempt_number   = fail_count;
            fail_count         = 3'd0;
            pending_results.push_back(r);
          end else begin
            record_failure(sfcc_pkg::ST_CRC_BAD);
          end
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender: one item per call. Inputs change on the falling edge; acceptance is
  // seen at the rising edge. valid stays high into the next call, so there is
  // no drop-and-raise within one step.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic kind, input logic [7:0] b);
    int unsigned gap;
    @(negedge clk);
    if (gaps_on && ($urandom_range(0, 5) == 0)) begin
      gap = $urandom_range(1, 16);
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.kind       = kind;
    in_ch.frame_byte = b;
    do @(posedge clk); while (!in_ch.ready);
    predict_frame_item(kind, b);
    items_sent++;
  endtask

  // Six-byte frame; corrupt[0] breaks the temperature CRC, corrupt[1] the
  // humidity CRC, each by a nonzero xor.
  task automatic send_frame(input logic [15:0] t, input logic [15:0] h,
                            input logic [1:0] corrupt);
    logic [7:0] c_t;
    logic [7:0] c_h;
    c_t = word_crc(t) ^ (corrupt[0] ? 8'($urandom_range(1, 255)) : 8'h00);
    c_h = word_crc(h) ^ (corrupt[1] ? 8'($urandom_range(1, 255)) : 8'h00);
    send_item(sfcc_pkg::KIND_BYTE, t[15:8]);
    send_item(sfcc_pkg::KIND_BYTE, t[7:0]);
    send_item(sfcc_pkg::KIND_BYTE, c_t);
    send_item(sfcc_pkg::KIND_BYTE, h[15:8]);
    send_item(sfcc_pkg::KIND_BYTE, h[7:0]);
    send_item(sfcc_pkg::KIND_BYTE, c_h);
  endtask

  task automatic send_bus_fail();
    send_item(sfcc_pkg::KIND_BUS_FAIL, 8'($urandom_range(0, 255)));
  endtask

  // Drop valid, wait for every expected result, then let the pipe empty of
  // items that cause none.
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write of max_attempts (setup + access), then read it back.
  task automatic set_attempt_limit(input logic [2:0] value);
    logic [31:0] rd;
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ADDR_MAX_ATTEMPTS;
    pwdata  = {29'd0, value};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (pready) attempt_limit = value;
    @(negedge clk);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    if (rd[2:0] !== attempt_limit) begin
      $error("max_attempts readback: expected %0d, actual %0d", attempt_limit, rd[2:0]);
      mismatch_count++;
    end
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random ready bursts, plus one long hold counted here on request.
  // ---------------------------------------------------------------------------
  initial begin : result_ready_drive
    int unsigned n;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold != 0) begin
        n = long_hold;
        long_hold = 0;
        out_ch.ready = 1'b0;
        repeat (n - 1) @(negedge clk);
      end else if (stalls_on && ($urandom_range(0, 7) == 0)) begin
        n = $urandom_range(1, 16);
        out_ch.ready = 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin : result_check
    sfcc_pkg::result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result item with nothing expected: status %0d attempt %0d",
               out_ch.status, out_ch.attempt_number);
        mismatch_count++;
      end else begin
        e = pending_results.pop_front();
        case (e.status)
          sfcc_pkg::ST_VALID:   valid_seen++;
          sfcc_pkg::ST_CRC_BAD: crc_bad_seen++;
          default:              bus_fail_seen++;
        endcase
        if (e.give_up) give_up_seen++;
        if (out_ch.status !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, out_ch.status);
          mismatch_count++;
        end
        if (out_ch.give_up !== e.give_up) begin
          $error("give_up: expected %0d, actual %0d", e.give_up, out_ch.give_up);
          mismatch_count++;
        end
        if (out_ch.temperature_word !== e.temperature_word) begin
          $error("temperature_word: expected %h, actual %h",
                 e.temperature_word, out_ch.temperature_word);
          mismatch_count++;
        end
        if (out_ch.humidity_word !== e.humidity_word) begin
          $error("humidity_word: expected %h, actual %h",
                 e.humidity_word, out_ch.humidity_word);
          mismatch_count++;
        end
        if (out_ch.attempt_number !== e.attempt_number) begin
          $error("attempt_number: expected %0d, actual %0d",
                 e.attempt_number, out_ch.attempt_number);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // After reset the limit reads 3; a fail with no bytes yet, a CRC fail and a
  // mid-frame bus fail use up all three attempts; then a good frame.
  task automatic test_attempt_count();
    send_bus_fail();                           // between frames: attempt 0
    send_frame(16'hBEEF, 16'h6666, 2'b10);     // humidity CRC bad: attempt 1
    send_item(sfcc_pkg::KIND_BYTE, 8'h12);
    send_item(sfcc_pkg::KIND_BYTE, 8'h34);
    send_bus_fail();                           // abandons frame, gives up
    send_frame(16'hBEEF, 16'h6666, 2'b00);     // clean, attempt 0
  endtask

  // Word extremes, plus a bad temperature CRC hidden behind a good humidity one.
  task automatic test_word_extremes();
    send_frame(16'hFFFF, 16'h0000, 2'b00);
    send_frame(16'h0000, 16'hFFFF, 2'b01);
  endtask

  // Limit at 7, three failures, then lowered below the count: next fail gives
  // up. Zero acts as one: every fail gives up at attempt 0.
  task automatic test_limit_changes();
    wait_idle();
    set_attempt_limit(3'd7);
    repeat (3) send_bus_fail();
    wait_idle();
    set_attempt_limit(3'd2);
    send_bus_fail();
    wait_idle();
    set_attempt_limit(3'd0);
    send_bus_fail();
    send_frame(16'h8001, 16'h7FFE, 2'b11);
    wait_idle();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  // bus failures and frames back to back, so the block fills and stalls in_ch.
  task automatic test_backpressure();
    set_attempt_limit(3'd4);
    gaps_on   = 1'b0;
    long_hold = 250;
    repeat (6) send_bus_fail();
    repeat (4) send_frame(pick_word(), pick_word(), 2'($urandom_range(0, 3)));
    repeat (6) send_bus_fail();
    gaps_on = 1'b1;
    wait_idle();
  endtask

  // Mostly well-formed frames with random words, plus CRC errors, truncated
  // frames, lone bus failures and raw noise.
  task automatic test_random_frames(input logic [2:0] limit, input int unsigned count);
    int unsigned goal;
    int unsigned pick;
    int unsigned n;
    set_attempt_limit(limit);
    goal = items_sent + count;
    while (items_sent < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_frame(pick_word(), pick_word(), 2'b00);
      end else if (pick < 70) begin
        send_frame(pick_word(), pick_word(), 2'($urandom_range(1, 3)));
      end else if (pick < 82) begin
        n = $urandom_range(0, 5);
        repeat (n) send_item(sfcc_pkg::KIND_BYTE, 8'($urandom_range(0, 255)));
        send_bus_fail();
      end else if (pick < 90) begin
        send_bus_fail();
      end else begin
        repeat (6) send_item(sfcc_pkg::KIND_BYTE, 8'($urandom_range(0, 255)));
      end
    end
    wait_idle();
  endtask

  // Overall watchdog.
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : main_seq
    int unsigned waited;
    // every input known from time 0
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.kind       = sfcc_pkg::KIND_BYTE;
    in_ch.frame_byte = 8'h00;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = 32'd0;
    gaps_on          = 1'b1;
    stalls_on        = 1'b1;
    long_hold        = 0;
    mismatch_count   = 0;
    items_sent       = 0;
    results_seen     = 0;
    valid_seen       = 0;
    crc_bad_seen     = 0;
    bus_fail_seen    = 0;
    give_up_seen     = 0;
    attempt_limit    = sfcc_pkg::MAX_ATTEMPTS_RST;
    fail_count       = 3'd0;
    temp_word        = 16'h0000;
    hum_word         = 16'h0000;
    restart_frame_model();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset value first: rewriting 3 keeps the model aligned and checks readback
    set_attempt_limit(sfcc_pkg::MAX_ATTEMPTS_RST);
    test_attempt_count();
    test_word_extremes();
    test_limit_changes();
    test_backpressure();

    test_random_frames(3'd7, 170);
    test_random_frames(3'd1, 170);
    test_random_frames(3'($urandom_range(2, 6)), 170);
    test_random_frames(3'd0, 100);
    test_random_frames(3'($urandom_range(1, 7)), 170);
    // last stretch: no idling on either side
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    test_random_frames(3'd5, 170);

    // bounded wait for stragglers, then a further wait for anything unexpected
    waited = 0;
    while (pending_results.size() != 0 && waited < END_WAIT_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected result items never arrived", pending_results.size());
      mismatch_count++;
    end

    $display("Covered %0d input items, %0d result items: %0d valid, %0d CRC bad,",
             items_sent, results_seen, valid_seen, crc_bad_seen);
    $display("%0d bus fail; limits 0..7 incl. lowering mid-count; %0d give-up results",
             bus_fail_seen, give_up_seen);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sensor_frame_crc_checker_unit.f
+incdir+rtl
rtl/sfcc_pkg.sv
rtl/sfcc_if.sv
rtl/sfcc_cfg.sv
rtl/sfcc_frame.sv
rtl/sensor_frame_crc_checker_unit.sv
sim/sensor_frame_crc_checker_unit_tb.sv
